// ===== src/greyscale_raster_engine_macros.svh =====
// assertion macros for the greyscale raster engine
// expects i_clk and i_rst_n in the scope of the user
`ifndef GREYSCALE_RASTER_ENGINE_MACROS_SVH
`define GREYSCALE_RASTER_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define GRE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("greyscale raster engine check failed");
`define GRE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("greyscale raster engine check failed");
`else
`define GRE_ASSERT_NOW(lbl, ante, cons)
`define GRE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== src/gre_pkg.sv =====
// shared types and constants of the greyscale raster engine
// no dependencies
package gre_pkg;

    localparam logic [2:0] KIND_CLEAR   = 3'd0;
    localparam logic [2:0] KIND_SET     = 3'd1;
    localparam logic [2:0] KIND_READ    = 3'd2;
    localparam logic [2:0] KIND_FILL    = 3'd3;
    localparam logic [2:0] KIND_OUTLINE = 3'd4;
    localparam logic [2:0] KIND_BLEND   = 3'd5;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PAPER_GREY   = 2'd2;

    localparam logic [1:0] PH_TOP    = 2'd0;
    localparam logic [1:0] PH_BOTTOM = 2'd1;
    localparam logic [1:0] PH_LEFT   = 2'd2;
    localparam logic [1:0] PH_RIGHT  = 2'd3;

    localparam logic [8:0]  FRAME_RESET = 9'd256;
    localparam logic [7:0]  PAPER_RESET = 8'd255;
    localparam logic [3:0]  BLEND_FULL  = 4'd15;
    localparam logic [11:0] RECIP15     = 12'd2185;
    localparam int          RECIP_SHIFT = 15;

    typedef struct packed {
        logic capture;
        logic pix_write;
        logic pix_read;
        logic clr_step;
        logic rect_setup;
        logic rect_step;
        logic phase_next;
        logic mul_step;
        logic blend_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic rect_empty;
        logic rect_last;
        logic rect_more;
    } t_dp_sts;

endpackage

// ===== src/greyscale_raster_engine.sv =====
// top level of the greyscale raster engine: config registers, sequencer, datapath
// depends on gre_pkg, gre_ctrl, gre_datapath and greyscale_raster_engine_macros.svh
//
// channel   signals                                direction  transfer at
// config    psel penable pwrite paddr pwdata       in         psel & penable & pwrite
// command   start, i_kind .. i_coverage            in         start & !busy
// result    o_done, o_read_grey, o_is_read         out        every cycle o_done is high
//
// set, read and unused kinds never leave idle; the result follows in the next cycle
// blend reads in idle, multiplies in S_BMUL, writes in S_BWR through one frame
// store read and write port; fill sets up in S_RSETUP, then walks the clipped
// rectangle in S_RWALK; outline runs four passes, top, bottom, left, right, each a
// setup and a walk; clear writes the whole store, one store entry per cycle
// after reset busy stays high while the store fills with the reset paper grey;
// results are one-cycle strobes and cannot be held off
`include "greyscale_raster_engine_macros.svh"
module greyscale_raster_engine #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [7:0]         i_grey,
    input  logic [3:0]         i_coverage,
    output logic               o_done,
    output logic [7:0]         o_read_grey,
    output logic               o_is_read
);

    logic [8:0] r_frame_width;
    logic [8:0] r_frame_height;
    logic [7:0] r_paper_grey;
    logic [1:0] cfg_idx;
    logic       cfg_wr;

    gre_pkg::t_dp_cmd dp_cmd;
    gre_pkg::t_dp_sts dp_sts;
    logic             ctrl_start;
    logic             read_taken;
    logic             set_taken;

    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= gre_pkg::FRAME_RESET;
            r_frame_height <= gre_pkg::FRAME_RESET;
            r_paper_grey   <= gre_pkg::PAPER_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                gre_pkg::REG_FRAME_WIDTH: begin
                    r_frame_width <= pwdata[8:0];
                end
                gre_pkg::REG_FRAME_HEIGHT: begin
                    r_frame_height <= pwdata[8:0];
                end
                gre_pkg::REG_PAPER_GREY: begin
                    r_paper_grey <= pwdata[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            gre_pkg::REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            gre_pkg::REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            gre_pkg::REG_PAPER_GREY:   prdata = 32'(r_paper_grey);
            default:                   prdata = '0;
        endcase
    end

    assign ctrl_start = start && !busy;
    assign read_taken = ctrl_start && (i_kind == gre_pkg::KIND_READ);
    assign set_taken  = ctrl_start && (i_kind == gre_pkg::KIND_SET);

    gre_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctrl_start),
        .i_kind  (i_kind),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    gre_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .i_paper_grey   (r_paper_grey),
        .i_kind         (i_kind),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_grey         (i_grey),
        .i_coverage     (i_coverage),
        .o_read_grey    (o_read_grey),
        .o_is_read      (o_is_read)
    );

    `GRE_ASSERT_NOW(a_done_when_idle, o_done, !busy)
    `GRE_ASSERT_NEXT(a_read_answers, read_taken, (o_done && o_is_read))
    `GRE_ASSERT_NEXT(a_set_one_cycle, set_taken, (o_done && !busy && !o_is_read))
    `GRE_ASSERT_NOW(a_other_grey_zero, (o_done && !o_is_read), (o_read_grey == 8'd0))

endmodule

// ===== src/gre_datapath.sv =====
// frame store, clipping, rectangle walker and blend arithmetic
// depends on gre_pkg
module gre_datapath #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gre_pkg::t_dp_cmd   i_cmd,
    output gre_pkg::t_dp_sts   o_sts,
    input  logic [8:0]         i_frame_width,
    input  logic [8:0]         i_frame_height,
    input  logic [7:0]         i_paper_grey,
    input  logic [2:0]         i_kind,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_rect_width,
    input  logic signed [15:0] i_rect_height,
    input  logic [7:0]         i_grey,
    input  logic [3:0]         i_coverage,
    output logic [7:0]         o_read_grey,
    output logic               o_is_read
);

    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0]     ROW_STEP = AW'(MAX_WIDTH);
    localparam logic [AW-1:0]     CLR_LAST = AW'(DEPTH - 1);
    localparam logic signed [18:0] FW_MAX  = 19'(MAX_WIDTH);
    localparam logic signed [18:0] FH_MAX  = 19'(MAX_HEIGHT);

    function automatic logic [AW-1:0] pix_addr(input logic [XW-1:0] cx,
                                                input logic [YW-1:0] cy);
        return AW'(AW'(cy) * ROW_STEP) + AW'(cx);
    endfunction

    logic [7:0] r_frame_store [DEPTH];
    logic [7:0] r_rdata;

    logic [2:0]         r_kind;
    logic signed [15:0] r_x;
    logic signed [15:0] r_y;
    logic signed [15:0] r_w;
    logic signed [15:0] r_h;
    logic [7:0]         r_grey;
    logic [3:0]         r_cov;
    logic               r_inside;
    logic [AW-1:0]      r_clr_addr;
    logic [1:0]         r_phase;
    logic [11:0]        r_sum;
    logic               r_empty;
    logic [XW-1:0]      r_x0;
    logic [XW-1:0]      r_xl;
    logic [XW-1:0]      r_cx;
    logic [YW-1:0]      r_yl;
    logic [YW-1:0]      r_cy;

    logic signed [18:0] fw;
    logic signed [18:0] fh;
    logic signed [18:0] in_x;
    logic signed [18:0] in_y;
    logic               in_inside;
    logic [AW-1:0]      in_addr;

    logic               outline;
    logic signed [18:0] rx;
    logic signed [18:0] ry;
    logic signed [18:0] rw;
    logic signed [18:0] rh;
    logic signed [18:0] px;
    logic signed [18:0] py;
    logic signed [18:0] pw;
    logic signed [18:0] ph;
    logic signed [18:0] xe;
    logic signed [18:0] ye;
    logic signed [18:0] x0;
    logic signed [18:0] y0;
    logic signed [18:0] x1;
    logic signed [18:0] y1;
    logic signed [18:0] xlast;
    logic signed [18:0] ylast;
    logic               n_empty;

    logic [3:0]  inv_cov;
    logic [11:0] n_sum;
    logic [23:0] prod;
    logic [7:0]  blend_q;
    logic        blend_ok;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // effective frame size and pixel hit test
    always_comb begin
        fw = $signed({10'd0, i_frame_width});
        fh = $signed({10'd0, i_frame_height});
        if (fw < 19'sd1) begin
            fw = 19'sd1;
        end
        if (fw > FW_MAX) begin
            fw = FW_MAX;
        end
        if (fh < 19'sd1) begin
            fh = 19'sd1;
        end
        if (fh > FH_MAX) begin
            fh = FH_MAX;
        end
        in_x      = 19'(i_pos_x);
        in_y      = 19'(i_pos_y);
        in_inside = (in_x >= 19'sd0) && (in_y >= 19'sd0) && (in_x < fw) && (in_y < fh);
        in_addr   = in_inside ? pix_addr(in_x[XW-1:0], in_y[YW-1:0]) : '0;
    end

    // rectangle clipping for the current outline side or the whole fill
    always_comb begin
        outline = (r_kind == gre_pkg::KIND_OUTLINE);
        rx = 19'(r_x);
        ry = 19'(r_y);
        rw = 19'(r_w);
        rh = 19'(r_h);
        pw = (outline && r_phase[1]) ? 19'sd1 : rw;
        ph = (outline && !r_phase[1]) ? 19'sd1 : rh;
        px = (outline && r_phase == gre_pkg::PH_RIGHT) ? rx + rw - 19'sd1 : rx;
        py = (outline && r_phase == gre_pkg::PH_BOTTOM) ? ry + rh - 19'sd1 : ry;
        xe = px + pw;
        ye = py + ph;
        x0 = (px < 19'sd0) ? 19'sd0 : px;
        y0 = (py < 19'sd0) ? 19'sd0 : py;
        x1 = (xe > fw) ? fw : xe;
        y1 = (ye > fh) ? fh : ye;
        xlast = x1 - 19'sd1;
        ylast = y1 - 19'sd1;
        n_empty = (rw <= 19'sd0) || (rh <= 19'sd0) || (x0 >= x1) || (y0 >= y1);
    end

    // blend: dst*(15-a) + ink*a, then divide by 15 through a reciprocal
    always_comb begin
        inv_cov  = gre_pkg::BLEND_FULL - r_cov;
        n_sum    = 12'(r_rdata) * 12'(inv_cov) + 12'(r_grey) * 12'(r_cov);
        prod     = 24'(r_sum) * 24'(gre_pkg::RECIP15);
        blend_q  = prod[gre_pkg::RECIP_SHIFT +: 8];
        blend_ok = r_inside && (r_cov != 4'd0) && (blend_q < r_rdata);
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.pix_write && in_inside) begin
            wr_en   = 1'b1;
            wr_addr = in_addr;
            wr_data = i_grey;
        end else if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = r_grey;
        end else if (i_cmd.rect_step && !r_empty) begin
            wr_en   = 1'b1;
            wr_addr = pix_addr(r_cx, r_cy);
            wr_data = r_grey;
        end else if (i_cmd.blend_wr && blend_ok) begin
            wr_en   = 1'b1;
            wr_addr = pix_addr(r_x[XW-1:0], r_y[YW-1:0]);
            wr_data = blend_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_frame_store[wr_addr] <= wr_data;
        end
        if (i_cmd.pix_read) begin
            r_rdata <= r_frame_store[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= gre_pkg::KIND_CLEAR;
            r_grey     <= gre_pkg::PAPER_RESET;
            r_clr_addr <= '0;
            r_phase    <= gre_pkg::PH_TOP;
        end else begin
            if (i_cmd.capture) begin
                r_kind     <= i_kind;
                r_x        <= i_pos_x;
                r_y        <= i_pos_y;
                r_w        <= i_rect_width;
                r_h        <= i_rect_height;
                r_grey     <= i_grey;
                r_cov      <= i_coverage;
                r_inside   <= in_inside;
                r_clr_addr <= '0;
                r_phase    <= gre_pkg::PH_TOP;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.rect_setup) begin
                r_empty <= n_empty;
                r_x0    <= x0[XW-1:0];
                r_cx    <= x0[XW-1:0];
                r_xl    <= xlast[XW-1:0];
                r_cy    <= y0[YW-1:0];
                r_yl    <= ylast[YW-1:0];
            end
            if (i_cmd.rect_step) begin
                if (r_cx == r_xl) begin
                    r_cx <= r_x0;
                    r_cy <= r_cy + YW'(1);
                end else begin
                    r_cx <= r_cx + XW'(1);
                end
            end
            if (i_cmd.phase_next) begin
                r_phase <= r_phase + 2'd1;
            end
            if (i_cmd.mul_step) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_sts.clr_last   = (r_clr_addr == CLR_LAST);
    assign o_sts.rect_empty = r_empty;
    assign o_sts.rect_last  = (r_cx == r_xl) && (r_cy == r_yl);
    assign o_sts.rect_more  = (r_kind == gre_pkg::KIND_OUTLINE) && (r_phase != gre_pkg::PH_RIGHT);

    assign o_is_read   = (r_kind == gre_pkg::KIND_READ);
    assign o_read_grey = !o_is_read ? 8'd0 : (r_inside ? r_rdata : i_paper_grey);

endmodule

// ===== src/gre_ctrl.sv =====
// command sequencer of the greyscale raster engine
// depends on gre_pkg, drives gre_datapath
module gre_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [2:0]       i_kind,
    input  gre_pkg::t_dp_sts i_sts,
    output gre_pkg::t_dp_cmd o_cmd,
    output logic             o_busy,
    output logic             o_done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_CLEAR  = 7'b0000100,
        S_RSETUP = 7'b0001000,
        S_RWALK  = 7'b0010000,
        S_BMUL   = 7'b0100000,
        S_BWR    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    case (i_kind)
                        gre_pkg::KIND_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        gre_pkg::KIND_SET: begin
                            o_cmd.pix_write = 1'b1;
                            n_done          = 1'b1;
                        end
                        gre_pkg::KIND_READ: begin
                            o_cmd.pix_read = 1'b1;
                            n_done         = 1'b1;
                        end
                        gre_pkg::KIND_FILL, gre_pkg::KIND_OUTLINE: begin
                            n_state = S_RSETUP;
                        end
                        gre_pkg::KIND_BLEND: begin
                            o_cmd.pix_read = 1'b1;
                            n_state        = S_BMUL;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                end
            end
            S_RSETUP: begin
                o_cmd.rect_setup = 1'b1;
                n_state          = S_RWALK;
            end
            S_RWALK: begin
                o_cmd.rect_step = !i_sts.rect_empty;
                if (i_sts.rect_empty || i_sts.rect_last) begin
                    if (i_sts.rect_more) begin
                        o_cmd.phase_next = 1'b1;
                        n_state          = S_RSETUP;
                    end else begin
                        n_state = S_IDLE;
                        n_done  = 1'b1;
                    end
                end
            end
            S_BMUL: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_BWR;
            end
            S_BWR: begin
                o_cmd.blend_wr = 1'b1;
                n_state        = S_IDLE;
                n_done         = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

endmodule

// ===== verif/tb_greyscale_raster_engine.sv =====
`timescale 1ns / 100ps
// testbench for greyscale_raster_engine: directed and random commands checked against
// a frame store model; depends on gre_pkg and the engine rtl only
module tb_greyscale_raster_engine;

    localparam int FB_W = 256;
    localparam int FB_H = 256;
    localparam int STALL_LIMIT = 4 * FB_W * FB_H + 1000;
    localparam int PHASE_ITEMS = 153;
    localparam logic [2:0] KIND_SPARE6 = 3'd6;
    localparam logic [2:0] KIND_SPARE7 = 3'd7;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct {
        logic [2:0]         kind;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] w;
        logic signed [15:0] h;
        logic [7:0]         grey;
        logic [3:0]         alpha;
    } t_raster_cmd;

    typedef struct {
        logic [7:0] grey;
        logic       rd;
    } t_pixel_reply;

    typedef struct {
        t_raster_cmd cmd;
        bit          typed;
        logic [7:0]  grey;
    } t_script_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               start;
    logic               busy;
    logic [2:0]         i_kind;
    logic signed [15:0] i_pos_x;
    logic signed [15:0] i_pos_y;
    logic signed [15:0] i_rect_width;
    logic signed [15:0] i_rect_height;
    logic [7:0]         i_grey;
    logic [3:0]         i_coverage;
    logic               o_done;
    logic [7:0]         o_read_grey;
    logic               o_is_read;

    // expectation typed into the directed table travels with the command
    logic               typed_row;
    logic [7:0]         typed_grey;

    logic [7:0]   pixel_mem [0:FB_W*FB_H-1];
    logic [8:0]   cfg_width;
    logic [8:0]   cfg_height;
    logic [7:0]   cfg_paper;
    t_pixel_reply expected_replies[$];
    int           in_flight;
    int           idle_cycles;
    int           errors;
    int           items_taken;
    int           results_seen;
    int           reads_seen;
    int           clears_taken;
    int           settings_run;
    t_script_row  script[$];

    greyscale_raster_engine #(
        .MAX_WIDTH(FB_W),
        .MAX_HEIGHT(FB_H)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .start(start),
        .busy(busy),
        .i_kind(i_kind),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_rect_width(i_rect_width),
        .i_rect_height(i_rect_height),
        .i_grey(i_grey),
        .i_coverage(i_coverage),
        .o_done(o_done),
        .o_read_grey(o_read_grey),
        .o_is_read(o_is_read)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int frame_span(logic [8:0] r, int lim);
        int d;
        d = int'(r);
        if (d < 1) d = 1;
        if (d > lim) d = lim;
        return d;
    endfunction

    function automatic bit in_frame(int x, int y);
        return x >= 0 && y >= 0 && x < frame_span(cfg_width, FB_W) &&
               y < frame_span(cfg_height, FB_H);
    endfunction

    task automatic paint_box(input int x, input int y, input int w, input int h,
                             input logic [7:0] g);
        int x0, x1, y0, y1;
        if (w <= 0 || h <= 0) return;
        x0 = x < 0 ? 0 : x;
        y0 = y < 0 ? 0 : y;
        x1 = x + w;
        y1 = y + h;
        if (x1 > frame_span(cfg_width, FB_W)) x1 = frame_span(cfg_width, FB_W);
        if (y1 > frame_span(cfg_height, FB_H)) y1 = frame_span(cfg_height, FB_H);
        for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++)
                pixel_mem[yy * FB_W + xx] = g;
    endtask

    task automatic raster_predict(input t_raster_cmd c, output t_pixel_reply r);
        int x, y, w, h, a, d, b;
        x = int'(c.x);
        y = int'(c.y);
        w = int'(c.w);
        h = int'(c.h);
        a = int'(c.alpha);
        r.grey = 8'h00;
        r.rd = 1'b0;
        case (c.kind)
            gre_pkg::KIND_CLEAR: begin
                for (int i = 0; i < FB_W * FB_H; i++) pixel_mem[i] = c.grey;
            end
            gre_pkg::KIND_SET: begin
                if (in_frame(x, y)) pixel_mem[y * FB_W + x] = c.grey;
            end
            gre_pkg::KIND_READ: begin
                r.rd = 1'b1;
                r.grey = in_frame(x, y) ? pixel_mem[y * FB_W + x] : cfg_paper;
            end
            gre_pkg::KIND_FILL: paint_box(x, y, w, h, c.grey);
            gre_pkg::KIND_OUTLINE: begin
                if (w > 0 && h > 0) begin
                    paint_box(x, y, w, 1, c.grey);
                    paint_box(x, y + h - 1, w, 1, c.grey);
                    paint_box(x, y, 1, h, c.grey);
                    paint_box(x + w - 1, y, 1, h, c.grey);
                end
            end
            gre_pkg::KIND_BLEND: begin
                if (a != 0 && in_frame(x, y)) begin
                    d = int'(pixel_mem[y * FB_W + x]);
                    b = (d * (15 - a) + int'(c.grey) * a) / 15;
                    if (b < d) pixel_mem[y * FB_W + x] = b[7:0];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_raster_cmd  cmd;
        t_pixel_reply want;
        t_pixel_reply next_reply;
        bit           moved;
        if (i_rst_n === 1'b1) begin
            moved = 1'b0;
            if (o_done === 1'b1) begin
                moved = 1'b1;
                if (expected_replies.size() == 0) begin
                    $display("%0t unexpected result: read_grey %0d is_read %0d",
                             $time, o_read_grey, o_is_read);
                    errors++;
                end else begin
                    want = expected_replies.pop_front();
                    results_seen++;
                    if (o_read_grey !== want.grey) begin
                        $display("%0t read_grey mismatch: expected %0d actual %0d",
                                 $time, want.grey, o_read_grey);
                        errors++;
                    end
                    if (o_is_read !== want.rd) begin
                        $display("%0t is_read mismatch: expected %0d actual %0d",
                                 $time, want.rd, o_is_read);
                        errors++;
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                moved = 1'b1;
                cmd.kind = i_kind;
                cmd.x = i_pos_x;
                cmd.y = i_pos_y;
                cmd.w = i_rect_width;
                cmd.h = i_rect_height;
                cmd.grey = i_grey;
                cmd.alpha = i_coverage;
                raster_predict(cmd, next_reply);
                if (typed_row) next_reply.grey = typed_grey;
                expected_replies.push_back(next_reply);
                items_taken++;
                if (cmd.kind == gre_pkg::KIND_READ) reads_seen++;
                if (cmd.kind == gre_pkg::KIND_CLEAR) clears_taken++;
            end
            in_flight <= expected_replies.size();
            idle_cycles <= moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t no transfer for %0d cycles", $time, idle_cycles);
                $display("[greyscale_raster_engine] ERROR");
                $finish;
            end
        end else begin
            for (int i = 0; i < FB_W * FB_H; i++) pixel_mem[i] = gre_pkg::PAPER_RESET;
        end
    end

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (in_flight != 0 || busy !== 1'b0);
    endtask

    task automatic issue(input t_raster_cmd c, input bit typed, input logic [7:0] tg,
                         input int pct);
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_kind <= c.kind;
        i_pos_x <= c.x;
        i_pos_y <= c.y;
        i_rect_width <= c.w;
        i_rect_height <= c.h;
        i_grey <= c.grey;
        i_coverage <= c.alpha;
        typed_row <= typed;
        typed_grey <= tg;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            gre_pkg::REG_FRAME_WIDTH:  cfg_width = value[8:0];
            gre_pkg::REG_FRAME_HEIGHT: cfg_height = value[8:0];
            gre_pkg::REG_PAPER_GREY:   cfg_paper = value[7:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input int w, input int h, input int paper, input bit spare);
        drain();
        write_reg(gre_pkg::REG_FRAME_WIDTH, ($urandom & ~32'h1FF) | w[8:0]);
        write_reg(gre_pkg::REG_FRAME_HEIGHT, ($urandom & ~32'h1FF) | h[8:0]);
        write_reg(gre_pkg::REG_PAPER_GREY, ($urandom & ~32'hFF) | paper[7:0]);
        if (spare) write_reg(REG_SPARE, $urandom);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [15:0] pick_coord(int span);
        if ($urandom_range(99) < 8) return 16'($urandom);
        return 16'(int'($urandom_range(span + 5)) - 3);
    endfunction

    function automatic logic signed [15:0] pick_extent(bit full_ok);
        int r;
        r = $urandom_range(99);
        if (full_ok && r < 8) return 16'($urandom);
        if (r < 16) return 16'(0 - int'($urandom_range(4)));
        return 16'($urandom_range(24, 1));
    endfunction

    function automatic t_raster_cmd random_command();
        t_raster_cmd c;
        int fw, fh, pick;
        fw = frame_span(cfg_width, FB_W);
        fh = frame_span(cfg_height, FB_H);
        pick = $urandom_range(99);
        c.grey = 8'($urandom_range(255));
        c.alpha = 4'($urandom_range(15));
        c.x = pick_coord(fw);
        c.y = pick_coord(fh);
        c.w = 16'($urandom);
        c.h = 16'($urandom);
        if (pick < 25) c.kind = gre_pkg::KIND_READ;
        else if (pick < 45) c.kind = gre_pkg::KIND_SET;
        else if (pick < 70) c.kind = gre_pkg::KIND_BLEND;
        else if (pick < 82) c.kind = gre_pkg::KIND_FILL;
        else if (pick < 94) c.kind = gre_pkg::KIND_OUTLINE;
        else if (pick < 97) c.kind = KIND_SPARE6;
        else c.kind = KIND_SPARE7;
        if (c.kind == gre_pkg::KIND_FILL || c.kind == gre_pkg::KIND_OUTLINE) begin
            c.w = pick_extent(c.kind == gre_pkg::KIND_OUTLINE || fw * fh <= 4096);
            c.h = pick_extent(c.kind == gre_pkg::KIND_OUTLINE || fw * fh <= 4096);
        end
        return c;
    endfunction

    task automatic run_phase(input int count, input int pct, input bit with_clear);
        t_raster_cmd c;
        for (int i = 0; i < count; i++) begin
            c = random_command();
            if (with_clear && i == count / 2) c.kind = gre_pkg::KIND_CLEAR;
            if (i == 60 || $urandom_range(99) == 0) drain();
            issue(c, 1'b0, 8'h00, (i % 50 < 10) ? 0 : pct);
        end
        settings_run++;
    endtask

    task automatic add_row(input logic [2:0] k, input int x, input int y, input int w,
                           input int h, input int g, input int a, input bit typed,
                           input int tg);
        t_script_row row;
        row.cmd.kind = k;
        row.cmd.x = 16'(x);
        row.cmd.y = 16'(y);
        row.cmd.w = 16'(w);
        row.cmd.h = 16'(h);
        row.cmd.grey = 8'(g);
        row.cmd.alpha = 4'(a);
        row.typed = typed;
        row.grey = 8'(tg);
        script.push_back(row);
    endtask

    initial begin
        cfg_width = gre_pkg::FRAME_RESET;
        cfg_height = gre_pkg::FRAME_RESET;
        cfg_paper = gre_pkg::PAPER_RESET;
        settings_run = 0;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        start <= 1'b0;
        i_kind <= gre_pkg::KIND_SET;
        i_pos_x <= '0;
        i_pos_y <= '0;
        i_rect_width <= '0;
        i_rect_height <= '0;
        i_grey <= '0;
        i_coverage <= '0;
        typed_row <= 1'b0;
        typed_grey <= '0;

        add_row(gre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, gre_pkg::PAPER_RESET);
        add_row(gre_pkg::KIND_READ, -1, 0, 0, 0, 0, 0, 1, gre_pkg::PAPER_RESET);
        add_row(gre_pkg::KIND_READ, 32767, -32768, 0, 0, 0, 0, 1, gre_pkg::PAPER_RESET);
        add_row(gre_pkg::KIND_SET, 0, 0, 0, 0, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_READ, 0, 0, 0, 0, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_SET, 255, 255, 0, 0, 8'hA5, 15, 1, 0);
        add_row(gre_pkg::KIND_READ, 255, 255, 0, 0, 0, 0, 1, 8'hA5);
        add_row(gre_pkg::KIND_SET, 256, 3, -1, -1, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_SET, -32768, -1, 0, 0, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_READ, 256, 3, 0, 0, 0, 0, 1, gre_pkg::PAPER_RESET);
        add_row(gre_pkg::KIND_FILL, 250, 250, 32767, 32767, 8'h10, 0, 1, 0);
        add_row(gre_pkg::KIND_READ, 255, 255, 0, 0, 0, 0, 1, 8'h10);
        add_row(gre_pkg::KIND_FILL, 3, 3, 0, 5, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_FILL, 3, 3, 5, -32768, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_OUTLINE, 10, 20, 6, 4, 8'h40, 0, 1, 0);
        add_row(gre_pkg::KIND_OUTLINE, 10, 20, -1, 4, 0, 0, 1, 0);
        add_row(gre_pkg::KIND_READ, 12, 20, 0, 0, 0, 0, 1, 8'h40);
        add_row(gre_pkg::KIND_READ, 12, 21, 0, 0, 0, 0, 1, gre_pkg::PAPER_RESET);
        add_row(gre_pkg::KIND_BLEND, 12, 20, 0, 0, 0, 0, 0, 0);
        add_row(gre_pkg::KIND_BLEND, 12, 20, 0, 0, 0, 15, 0, 0);
        add_row(gre_pkg::KIND_BLEND, 1, 1, 0, 0, 8'h3C, 7, 0, 0);
        add_row(gre_pkg::KIND_BLEND, 0, 0, 0, 0, 8'hFF, 9, 0, 0);
        add_row(gre_pkg::KIND_READ, 1, 1, 0, 0, 0, 0, 0, 0);
        add_row(KIND_SPARE6, 5, 5, 5, 5, 8'hFF, 15, 1, 0);
        add_row(KIND_SPARE7, 5, 5, 5, 5, 8'hFF, 15, 1, 0);
        add_row(gre_pkg::KIND_CLEAR, 0, 0, 0, 0, 8'h33, 0, 1, 0);
        add_row(gre_pkg::KIND_READ, 100, 100, 0, 0, 0, 0, 1, 8'h33);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);

        foreach (script[i]) issue(script[i].cmd, script[i].typed, script[i].grey, 0);
        drain();

        run_phase(PHASE_ITEMS, 0, 1'b0);
        set_frame(0, 0, 0, 1'b0);
        run_phase(PHASE_ITEMS, 53, 1'b0);
        set_frame(511, 511, 128, 1'b0);
        run_phase(PHASE_ITEMS, 20, 1'b1);
        set_frame(16, 9, 255, 1'b1);
        run_phase(PHASE_ITEMS, 0, 1'b0);
        set_frame(1, 256, 7, 1'b0);
        run_phase(PHASE_ITEMS, 53, 1'b0);
        set_frame(256, 1, 200, 1'b0);
        run_phase(PHASE_ITEMS, 20, 1'b1);
        set_frame(37, 23, $urandom_range(255), 1'b0);
        run_phase(PHASE_ITEMS, 53, 1'b0);
        set_frame(256, 256, 255, 1'b0);
        run_phase(PHASE_ITEMS, 0, 1'b1);

        drain();
        repeat (8) @(posedge i_clk);
        $display("covered %0d commands and %0d results over %0d frame settings",
                 items_taken, results_seen, settings_run);
        $display("including %0d pixel reads and %0d full clears", reads_seen, clears_taken);
        if (errors == 0 && expected_replies.size() == 0) begin
            $display("[greyscale_raster_engine] OK");
        end else begin
            $display("[greyscale_raster_engine] ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/gre_pkg.sv
src/gre_datapath.sv
src/gre_ctrl.sv
src/greyscale_raster_engine.sv
verif/tb_greyscale_raster_engine.sv
